// ===== hw/rtl/tpc_pkg.sv =====
package tpc_pkg;

  localparam int IN_FRAC     = 10;
  localparam int OUT_FRAC    = 16;
  localparam int SCALE_SHIFT = 2 * (IN_FRAC + OUT_FRAC + 1);

  typedef struct packed {
    logic degen;
    logic flat;
    logic neg;
    logic sat;
  } tpc_flags_t;

endpackage

// ===== hw/rtl/tpc_front.sv =====
module tpc_front
  import tpc_pkg::*;
#(
  parameter int CW = 16,
  parameter int NW = 124,
  parameter int PW = 105
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [CW-1:0]        x1_i,
  input  logic [CW-1:0]        y1_i,
  input  logic [CW-1:0]        x2_i,
  input  logic [CW-1:0]        y2_i,
  input  logic [CW-1:0]        x3_i,
  input  logic [CW-1:0]        y3_i,
  output logic                 valid_o,
  output logic [NW-1:0]        num_o,
  output logic [PW-1:0]        prod_o,
  output tpc_flags_t           flags_o
);

  localparam int DW  = CW + 1;
  localparam int QW  = 2 * DW + 1;
  localparam int CRW = 2 * DW + 1;
  localparam int TW  = DW + QW + 3;

  logic [5:0] v;

  // stage 1: differences
  logic signed [DW-1:0] d1x, d1y, d2x, d2y, d3x, d3y;
  logic signed [CW-1:0] y1a;

  // stage 2: products
  logic signed [2*DW-1:0] pa, pb;
  logic signed [2*DW-1:0] s1x, s1y, s2x, s2y, s3x, s3y;
  logic signed [DW-1:0]   d1x2, d2x2;
  logic signed [CW-1:0]   y1b;

  // stage 3: cross and squared lengths
  logic signed [CRW-1:0] cr;
  logic [QW-1:0]         q1, q2, q3;
  logic signed [DW-1:0]  d1x3, d2x3;
  logic signed [CW-1:0]  y1c;

  // stage 4
  logic signed [DW+QW:0]  t1, t2;
  logic signed [CW+CRW:0] t3;
  logic [2*CRW-1:0]       cr2;
  logic [2*QW-1:0]        p12;
  logic [QW-1:0]          q3d;
  logic                   crz, crneg;

  // stage 5
  logic [NW-1:0]   num5;
  logic [2*QW-1:0] plo, phi;
  tpc_flags_t      fl5;

  logic signed [TW-1:0] s_sum;
  logic signed [CW:0]   y2x;

  assign y2x   = {y1c, 1'b0};
  assign s_sum = TW'(t3) + TW'(t1) - TW'(t2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1x <= DW'($signed(x2_i)) - DW'($signed(x1_i));
      d1y <= DW'($signed(y2_i)) - DW'($signed(y1_i));
      d2x <= DW'($signed(x3_i)) - DW'($signed(x1_i));
      d2y <= DW'($signed(y3_i)) - DW'($signed(y1_i));
      d3x <= DW'($signed(x3_i)) - DW'($signed(x2_i));
      d3y <= DW'($signed(y3_i)) - DW'($signed(y2_i));
      y1a <= $signed(y1_i);

      pa   <= (2*DW)'(d1x) * (2*DW)'(d2y);
      pb   <= (2*DW)'(d1y) * (2*DW)'(d2x);
      s1x  <= (2*DW)'(d1x) * (2*DW)'(d1x);
      s1y  <= (2*DW)'(d1y) * (2*DW)'(d1y);
      s2x  <= (2*DW)'(d2x) * (2*DW)'(d2x);
      s2y  <= (2*DW)'(d2y) * (2*DW)'(d2y);
      s3x  <= (2*DW)'(d3x) * (2*DW)'(d3x);
      s3y  <= (2*DW)'(d3y) * (2*DW)'(d3y);
      d1x2 <= d1x;
      d2x2 <= d2x;
      y1b  <= y1a;

      cr   <= CRW'(pa) - CRW'(pb);
      q1   <= QW'(unsigned'(s1x)) + QW'(unsigned'(s1y));
      q2   <= QW'(unsigned'(s2x)) + QW'(unsigned'(s2y));
      q3   <= QW'(unsigned'(s3x)) + QW'(unsigned'(s3y));
      d1x3 <= d1x2;
      d2x3 <= d2x2;
      y1c  <= y1b;

      t1    <= (DW+QW+1)'(d1x3) * (DW+QW+1)'($signed({1'b0, q2}));
      t2    <= (DW+QW+1)'(d2x3) * (DW+QW+1)'($signed({1'b0, q1}));
      t3    <= (CW+CRW+1)'(y2x) * (CW+CRW+1)'(cr);
      cr2   <= unsigned'((2*CRW)'(cr) * (2*CRW)'(cr));
      p12   <= (2*QW)'(q1) * (2*QW)'(q2);
      q3d   <= q3;
      crz   <= (cr == '0);
      crneg <= cr[CRW-1];

      num5 <= NW'(cr2) << SCALE_SHIFT;
      plo  <= (2*QW)'(p12[QW-1:0]) * (2*QW)'(q3d);
      phi  <= (2*QW)'(p12[2*QW-1:QW]) * (2*QW)'(q3d);
      fl5  <= '{degen: crz, flat: (s_sum == '0), neg: s_sum[TW-1] ^ crneg, sat: 1'b0};

      num_o   <= num5;
      prod_o  <= PW'(plo) + (PW'(phi) << QW);
      flags_o <= fl5;
    end
  end

  assign valid_o = v[5];

endmodule

// ===== hw/rtl/tpc_div_cell.sv =====
module tpc_div_cell
  import tpc_pkg::*;
#(
  parameter int WW    = 170,
  parameter int PW    = 105,
  parameter int QB    = 63,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_i,
  input  logic [WW-1:0] rem_i,
  input  logic [PW-1:0] prod_i,
  input  logic [QB-1:0] q_i,
  input  tpc_flags_t    flags_i,
  output logic          valid_o,
  output logic [WW-1:0] rem_o,
  output logic [PW-1:0] prod_o,
  output logic [QB-1:0] q_o,
  output tpc_flags_t    flags_o
);

  logic [WW-1:0] sh;
  logic          ge;

  assign sh = WW'(prod_i) << SHIFT;
  assign ge = (rem_i >= sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o   <= ge ? rem_i - sh : rem_i;
      q_o     <= ge ? (q_i | (QB'(1) << SHIFT)) : q_i;
      prod_o  <= prod_i;
      flags_o <= flags_i;
    end
  end

endmodule

// ===== hw/rtl/tpc_sqrt_cell.sv =====
module tpc_sqrt_cell
  import tpc_pkg::*;
#(
  parameter int RB = 62,
  parameter int MB = 31,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_i,
  input  logic [RB-1:0] rem_i,
  input  logic [MB-1:0] m_i,
  input  tpc_flags_t    flags_i,
  output logic          valid_o,
  output logic [RB-1:0] rem_o,
  output logic [MB-1:0] m_o,
  output tpc_flags_t    flags_o
);

  logic [RB-1:0] trial;
  logic          ge;

  assign trial = (RB'(m_i) << (K + 1)) | (RB'(1) << (2 * K));
  assign ge    = (rem_i >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o   <= ge ? rem_i - trial : rem_i;
      m_o     <= ge ? (m_i | (MB'(1) << K)) : m_i;
      flags_o <= flags_i;
    end
  end

endmodule

// ===== hw/rtl/three_point_curvature_unit.sv =====
// three point curvature unit
// takes three 2d points (signed, 10 fractional bits) per transaction on the
// item channel and returns one transaction on the result channel: signed
// curvature with 16 fractional bits and the sign of the circle center y,
// a degenerate flag for collinear or coincident points and a saturated flag
// the datapath is a row of pipeline cells: a 6 stage front end for the
// products, one restoring divider cell per quotient bit (2*CURV_WIDTH-1
// cells) and one square root cell per result bit (CURV_WIDTH-1 cells)
// throughput is one transaction per cycle while the result side takes them
// when result_stall is high with a result waiting, the whole row holds and
// item_stall is raised in the same cycle; nothing is lost or repeated
// reset clears every valid bit in the row; payload registers are not reset
// results leave in the order the items came in
module three_point_curvature_unit
  import tpc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int CURV_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [CURV_WIDTH-1:0] curvature,
  output logic                         degenerate,
  output logic                         saturated
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int QW   = 2 * DW + 1;
  localparam int CRW  = 2 * DW + 1;
  localparam int NW   = 2 * CRW + SCALE_SHIFT;
  localparam int PW   = 3 * QW;
  localparam int QB   = 2 * CURV_WIDTH - 1;
  localparam int RB   = 2 * CURV_WIDTH - 2;
  localparam int MB   = CURV_WIDTH - 1;
  localparam int WW   = ((NW > PW + QB) ? NW : PW + QB) + 1;

  logic en;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  logic          fv;
  logic [NW-1:0] fnum;
  logic [PW-1:0] fprod;
  tpc_flags_t    ffl;

  tpc_front #(
    .CW (COORD_WIDTH),
    .NW (NW),
    .PW (PW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_i (item_valid),
    .x1_i    (first_x),
    .y1_i    (first_y),
    .x2_i    (second_x),
    .y2_i    (second_y),
    .x3_i    (third_x),
    .y3_i    (third_y),
    .valid_o (fv),
    .num_o   (fnum),
    .prod_o  (fprod),
    .flags_o (ffl)
  );

  logic          dv   [0:QB];
  logic [WW-1:0] drem [0:QB];
  logic [PW-1:0] dprod[0:QB];
  logic [QB-1:0] dq   [0:QB];
  tpc_flags_t    dfl  [0:QB];

  assign dv[0]    = fv;
  assign drem[0]  = WW'(fnum);
  assign dprod[0] = fprod;
  assign dq[0]    = '0;
  assign dfl[0]   = ffl;

  for (genvar i = 0; i < QB; i++) begin : g_div
    tpc_div_cell #(
      .WW    (WW),
      .PW    (PW),
      .QB    (QB),
      .SHIFT (QB - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (dv[i]),
      .rem_i   (drem[i]),
      .prod_i  (dprod[i]),
      .q_i     (dq[i]),
      .flags_i (dfl[i]),
      .valid_o (dv[i+1]),
      .rem_o   (drem[i+1]),
      .prod_o  (dprod[i+1]),
      .q_o     (dq[i+1]),
      .flags_o (dfl[i+1])
    );
  end

  logic          sv   [0:MB];
  logic [RB-1:0] srem [0:MB];
  logic [MB-1:0] sm   [0:MB];
  tpc_flags_t    sfl  [0:MB];

  assign sv[0]   = dv[QB];
  assign srem[0] = dq[QB][RB-1:0];
  assign sm[0]   = '0;
  assign sfl[0]  = '{degen: dfl[QB].degen, flat: dfl[QB].flat, neg: dfl[QB].neg,
                     sat: dq[QB][QB-1]};

  for (genvar j = 0; j < MB; j++) begin : g_sqrt
    tpc_sqrt_cell #(
      .RB (RB),
      .MB (MB),
      .K  (MB - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_i (sv[j]),
      .rem_i   (srem[j]),
      .m_i     (sm[j]),
      .flags_i (sfl[j]),
      .valid_o (sv[j+1]),
      .rem_o   (srem[j+1]),
      .m_o     (sm[j+1]),
      .flags_o (sfl[j+1])
    );
  end

  tpc_flags_t            ofl;
  logic [MB-1:0]         mag;
  logic [CURV_WIDTH-1:0] curv_next;
  logic                  zero_out;

  assign ofl      = sfl[MB];
  assign zero_out = ofl.degen || ofl.flat;
  assign mag      = ofl.sat ? '1 : sm[MB];

  always_comb begin
    if (zero_out) begin
      curv_next = '0;
    end else if (ofl.neg) begin
      curv_next = '0 - CURV_WIDTH'(mag);
    end else begin
      curv_next = CURV_WIDTH'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sv[MB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      curvature  <= $signed(curv_next);
      degenerate <= ofl.degen;
      saturated  <= ofl.sat && !zero_out;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_WIDTH = 16;
  localparam int CURV_WIDTH  = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [CURV_WIDTH-1:0] curvature;
    logic                         degenerate;
    logic                         saturated;
  } curv_result_t;

  logic                          clk;
  logic                          rst;
  logic                          item_valid;
  logic                          item_stall;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] third_x;
  logic signed [COORD_WIDTH-1:0] third_y;
  logic                          result_valid;
  logic                          result_stall;
  logic signed [CURV_WIDTH-1:0]  curvature;
  logic                          degenerate;
  logic                          saturated;

  curv_result_t pending_curvature[$];
  int  error_count = 0;
  int  quiet_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  three_point_curvature_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .CURV_WIDTH (CURV_WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .first_x     (first_x),
    .first_y     (first_y),
    .second_x    (second_x),
    .second_y    (second_y),
    .third_x     (third_x),
    .third_y     (third_y),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .curvature   (curvature),
    .degenerate  (degenerate),
    .saturated   (saturated)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic bit curve_fits(input logic [255:0] m, input logic [255:0] prod,
                                    input logic [255:0] num);
    return (m * m * prod) <= num;
  endfunction

  function automatic curv_result_t predict_curvature(
      input logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy);
    curv_result_t r;
    longint x1, y1, d1x, d1y, d2x, d2y, d3x, d3y;
    longint cr, crabs, q1, q2, q3, ny, s;
    logic [255:0] num, prod, top;
    logic [CURV_WIDTH-1:0] m, cand;
    bit neg;
    int k;
    r = '0;
    x1 = longint'(ax);
    y1 = longint'(ay);
    d1x = longint'(bx) - x1;
    d1y = longint'(by) - y1;
    d2x = longint'(cx) - x1;
    d2y = longint'(cy) - y1;
    d3x = longint'(cx) - longint'(bx);
    d3y = longint'(cy) - longint'(by);
    cr = d1x * d2y - d1y * d2x;
    if (cr == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    q1 = d1x * d1x + d1y * d1y;
    q2 = d2x * d2x + d2y * d2y;
    q3 = d3x * d3x + d3y * d3y;
    ny = d1x * q2 - d2x * q1;
    s = 2 * y1 * cr + ny;
    if (s == 0) return r;
    neg = (s < 0) != (cr < 0);
    crabs = (cr < 0) ? -cr : cr;
    num = (256'(crabs) * 256'(crabs)) << (2 * (10 + 16 + 1));
    prod = 256'(q1) * 256'(q2) * 256'(q3);
    top = 256'(1) << (CURV_WIDTH - 1);
    m = '0;
    if (curve_fits(top, prod, num)) begin
      m = {1'b0, {(CURV_WIDTH-1){1'b1}}};
      r.saturated = 1'b1;
    end else begin
      for (k = CURV_WIDTH - 2; k >= 0; k--) begin
        cand = m | (CURV_WIDTH'(1) << k);
        if (curve_fits(256'(cand), prod, num)) m = cand;
      end
    end
    r.curvature = neg ? -m : m;
    return r;
  endfunction

  task automatic send_points(input logic [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy);
    if (!quiet && $urandom_range(99) < 20) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    first_x <= ax;
    first_y <= ay;
    second_x <= bx;
    second_y <= by;
    third_x <= cx;
    third_y <= cy;
    do @(posedge clk); while (item_stall);
    pending_curvature.insert(pending_curvature.size(),
                             predict_curvature(ax, ay, bx, by, cx, cy));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_curvature.size() != 0) @(posedge clk);
  endtask

  // random triple: general, tight triangle, collinear, coincident, x axis centre
  task automatic send_random_triple();
    logic [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy;
    int sel, dx, dy, kk;
    sel = $urandom_range(99);
    ax = COORD_WIDTH'($urandom);
    ay = COORD_WIDTH'($urandom);
    bx = COORD_WIDTH'($urandom);
    by = COORD_WIDTH'($urandom);
    cx = COORD_WIDTH'($urandom);
    cy = COORD_WIDTH'($urandom);
    if (sel < 40) begin
    end else if (sel < 65) begin
      ax = COORD_WIDTH'($urandom_range(0, 60000) - 30000);
      ay = COORD_WIDTH'($urandom_range(0, 60000) - 30000);
      bx = COORD_WIDTH'(ax + $urandom_range(0, 16) - 8);
      by = COORD_WIDTH'(ay + $urandom_range(0, 16) - 8);
      cx = COORD_WIDTH'(ax + $urandom_range(0, 16) - 8);
      cy = COORD_WIDTH'(ay + $urandom_range(0, 16) - 8);
    end else if (sel < 78) begin
      dx = int'($urandom_range(0, 200)) - 100;
      dy = int'($urandom_range(0, 200)) - 100;
      kk = int'($urandom_range(0, 100)) - 50;
      ax = COORD_WIDTH'($urandom_range(0, 40000) - 20000);
      ay = COORD_WIDTH'($urandom_range(0, 40000) - 20000);
      bx = COORD_WIDTH'(int'(ax) + dx);
      by = COORD_WIDTH'(int'(ay) + dy);
      cx = COORD_WIDTH'(int'(ax) + kk * dx);
      cy = COORD_WIDTH'(int'(ay) + kk * dy);
    end else if (sel < 86) begin
      case ($urandom_range(2))
        0: begin bx = ax; by = ay; end
        1: begin cx = ax; cy = ay; end
        default: begin cx = bx; cy = by; end
      endcase
    end else begin
      ay = COORD_WIDTH'($urandom_range(1, 32767));
      bx = ax;
      by = -ay;
    end
    send_points(ax, ay, bx, by, cx, cy);
  endtask

  task automatic test_directed();
    send_points(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_points(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_points(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff);
    send_points(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h8000);
    send_points(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    send_points(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_points(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hffff);
    send_points(16'h7fff, 16'h7fff, 16'h7ffe, 16'h7fff, 16'h7fff, 16'h7ffe);
    send_points(16'h8000, 16'h8000, 16'h8001, 16'h8000, 16'h8000, 16'h8001);
    send_points(16'hfc00, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400);
    send_points(16'hfc00, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'hfc00);
    send_points(16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0800, 16'h0800);
    send_points(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
    send_points(16'h0005, 16'h0007, 16'h0005, 16'h0007, 16'h0064, 16'h0003);
    send_points(16'h0064, 16'h00c8, 16'h012c, 16'h0190, 16'h0064, 16'h00c8);
    send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_points(16'hffff, 16'hffff, 16'h0001, 16'hffff, 16'h0000, 16'hfffe);
    send_points(16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h5555, 16'haaaa);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      quiet = (i < 300);
      send_random_triple();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 200; i++) send_random_triple();
    wait_drained();
  endtask

  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 50; i++) send_random_triple();
    wait_drained();
    repeat (5) @(posedge clk);
    for (i = 0; i < 50; i++) send_random_triple();
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_stall <= !quiet && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    curv_result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_curvature.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        exp_r = pending_curvature.pop_front();
        if (curvature !== exp_r.curvature) begin
          $error("curvature expected %0d actual %0d", exp_r.curvature, curvature);
          error_count++;
        end
        if (degenerate !== exp_r.degenerate) begin
          $error("degenerate expected %0d actual %0d", exp_r.degenerate, degenerate);
          error_count++;
        end
        if (saturated !== exp_r.saturated) begin
          $error("saturated expected %0d actual %0d", exp_r.saturated, saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    first_x = '0;
    first_y = '0;
    second_x = '0;
    second_y = '0;
    third_x = '0;
    third_y = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1100);
    test_backpressure();
    test_sender_pause();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
